### rtl/core/stt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the source text tokenizer.
// Holds the token record type, token kind codes and the character class functions.
package stt_pkg;

    typedef struct packed {
        logic [5:0]  kind;
        logic [23:0] offset;
        logic [15:0] length;
        logic [15:0] line;
        logic [15:0] column;
        logic        last;
    } t_token;

    localparam logic [5:0] K_FLOAT   = 6'd5;
    localparam logic [5:0] K_INT     = 6'd6;
    localparam logic [5:0] K_IDENT   = 6'd13;
    localparam logic [5:0] K_STRING  = 6'd14;
    localparam logic [5:0] K_CHAR    = 6'd15;
    localparam logic [5:0] K_COLONEQ = 6'd16;
    localparam logic [5:0] K_ARROW   = 6'd17;
    localparam logic [5:0] K_LE      = 6'd18;
    localparam logic [5:0] K_GE      = 6'd19;
    localparam logic [5:0] K_EQEQ    = 6'd20;
    localparam logic [5:0] K_NE      = 6'd21;
    localparam logic [5:0] K_DEC     = 6'd22;
    localparam logic [5:0] K_INC     = 6'd23;
    localparam logic [5:0] K_PLUS    = 6'd24;
    localparam logic [5:0] K_MINUS   = 6'd25;
    localparam logic [5:0] K_BANG    = 6'd26;
    localparam logic [5:0] K_PERCENT = 6'd27;
    localparam logic [5:0] K_STAR    = 6'd28;
    localparam logic [5:0] K_SLASH   = 6'd29;
    localparam logic [5:0] K_ASSIGN  = 6'd30;
    localparam logic [5:0] K_GT      = 6'd31;
    localparam logic [5:0] K_LT      = 6'd32;
    localparam logic [5:0] K_COMMA   = 6'd33;
    localparam logic [5:0] K_SEMI    = 6'd34;
    localparam logic [5:0] K_LPAREN  = 6'd35;
    localparam logic [5:0] K_RPAREN  = 6'd36;
    localparam logic [5:0] K_LBRACK  = 6'd37;
    localparam logic [5:0] K_RBRACK  = 6'd38;
    localparam logic [5:0] K_LBRACE  = 6'd39;
    localparam logic [5:0] K_RBRACE  = 6'd40;
    localparam logic [5:0] K_COMMENT = 6'd41;
    localparam logic [5:0] K_ILLEGAL = 6'd42;
    localparam logic [5:0] K_END     = 6'd43;
    localparam logic [5:0] K_NONE    = 6'd0;

    localparam int NUM_KW = 13;
    localparam logic [47:0] KW_TEXT [NUM_KW] = '{
        48'("let"), 48'("fn"), 48'("match"), 48'("case"), 48'("return"),
        48'("float"), 48'("int"), 48'("if"), 48'("else"), 48'("for"),
        48'("while"), 48'("true"), 48'("false")};
    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd3, 3'd2, 3'd5, 3'd4, 3'd6, 3'd5, 3'd3, 3'd2, 3'd4, 3'd3,
        3'd5, 3'd4, 3'd5};

    // Keyword kinds equal the keyword's place in the table.
    function automatic logic [5:0] word_kind(input logic [47:0] prefix,
                                             input logic [2:0] len);
        logic [5:0] k;
        k = K_IDENT;
        for (int i = NUM_KW - 1; i >= 0; i--) begin
            if (len == KW_LEN[i] && prefix == KW_TEXT[i]) begin
                k = 6'(i);
            end
        end
        return k;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == "_";
    endfunction

    function automatic logic is_opchar(input logic [7:0] c);
        return c == ":" || c == "+" || c == "-" || c == "/" || c == "%" ||
               c == "=" || c == ">" || c == "!" || c == "<" || c == "*";
    endfunction

    function automatic logic [5:0] single_op_kind(input logic [7:0] c);
        logic [5:0] k;
        unique case (c)
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "!":     k = K_BANG;
            "%":     k = K_PERCENT;
            "*":     k = K_STAR;
            "/":     k = K_SLASH;
            "=":     k = K_ASSIGN;
            ">":     k = K_GT;
            "<":     k = K_LT;
            default: k = K_ILLEGAL;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
        logic [5:0] k;
        priority if (a == ":" && b == "=") k = K_COLONEQ;
        else if (a == "-" && b == ">") k = K_ARROW;
        else if (a == "<" && b == "=") k = K_LE;
        else if (a == ">" && b == "=") k = K_GE;
        else if (a == "=" && b == "=") k = K_EQEQ;
        else if (a == "!" && b == "=") k = K_NE;
        else if (a == "-" && b == "-") k = K_DEC;
        else if (a == "+" && b == "+") k = K_INC;
        else k = K_NONE;
        return k;
    endfunction

    function automatic logic [5:0] punct_kind(input logic [7:0] c);
        logic [5:0] k;
        unique case (c)
            ",":     k = K_COMMA;
            ";":     k = K_SEMI;
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "[":     k = K_LBRACK;
            "]":     k = K_RBRACK;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            default: k = K_ILLEGAL;
        endcase
        return k;
    endfunction

endpackage

### rtl/core/source_text_tokenizer.sv
`timescale 1ns / 1ps
// Top level of the source text tokenizer: byte request channel in, token channel out.
// Depends on stt_pkg, stt_scan and stt_queue.
//
// Usage: source bytes arrive on the request channel (i_valid / o_stall) with
// i_end_of_text marking the end; a zero byte also ends the text. Each request
// yields zero, one or two tokens on the result channel (o_valid / i_stall);
// o_last_of_item flags the final token of a request.
// Throughput: one request per cycle. The scanner works out all tokens of a byte
// in the cycle it is taken and writes them into a four-entry token queue; a
// request is refused (o_stall high) while fewer than two queue slots are free,
// so a byte that yields two tokens lowers the sustained rate, since the
// output side drains at most one token per cycle.
// A token is written into the queue and appears on the output in the cycle after
// the request that caused it, provided the queue ahead of it is empty.
// Reset (synchronous, active low) empties the queue and returns the scanner to
// the start of text: offset 0, line 1, column 0. After the end of text every
// request gives one end token until reset. While the receiver stalls, the head
// token holds steady and requests keep being taken until the queue fills.
module source_text_tokenizer #(
    parameter int OFFSET_BITS = 24,
    parameter int COUNT_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_token_kind,
    output logic [23:0] o_start_offset,
    output logic [15:0] o_token_length,
    output logic [15:0] o_line_number,
    output logic [15:0] o_column_number,
    output logic        o_last_of_item
);

    logic            go, full;
    logic [1:0]      push_n;
    stt_pkg::t_token tok0, tok1, head;

    assign o_stall = full;
    assign go      = i_valid && !full;

    stt_scan #(
        .OFFSET_BITS(OFFSET_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_byte  (i_text_byte),
        .i_eot   (i_end_of_text),
        .o_push_n(push_n),
        .o_tok0  (tok0),
        .o_tok1  (tok1)
    );

    stt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push_n(push_n),
        .i_tok0  (tok0),
        .i_tok1  (tok1),
        .o_full  (full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_tok   (head)
    );

    assign o_token_kind    = head.kind;
    assign o_start_offset  = head.offset;
    assign o_token_length  = head.length;
    assign o_line_number   = head.line;
    assign o_column_number = head.column;
    assign o_last_of_item  = head.last;

    a_no_take_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> push_n == 2'd0)
        else $error("request taken while queue full");
    a_every_request_answers_or_ends: assert property (@(posedge i_clk)
        disable iff (!i_rst_n)
        (go && (i_end_of_text || i_text_byte == 8'd0)) |-> push_n != 2'd0)
        else $error("end of text produced no token");
    a_two_token_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_n == 2'd2 |-> (!tok0.last && tok1.last))
        else $error("last flag misplaced on a two-token request");

endmodule

### rtl/core/stt_scan.sv
`timescale 1ns / 1ps
// Scanner core: holds the lexer state and turns one accepted byte into up to two tokens.
// Depends on stt_pkg for the token record, kind codes and character classes.
module stt_scan #(
    parameter int OFFSET_BITS = 24,
    parameter int COUNT_BITS  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic [7:0]          i_byte,
    input  logic                i_eot,
    output logic [1:0]          o_push_n,
    output stt_pkg::t_token     o_tok0,
    output stt_pkg::t_token     o_tok1
);

    localparam logic [3:0] M_IDLE     = 4'd0;
    localparam logic [3:0] M_IDENT    = 4'd1;
    localparam logic [3:0] M_NUM      = 4'd2;
    localparam logic [3:0] M_STR      = 4'd3;
    localparam logic [3:0] M_CH_FIRST = 4'd4;
    localparam logic [3:0] M_CH_ESC   = 4'd5;
    localparam logic [3:0] M_CH_CLOSE = 4'd6;
    localparam logic [3:0] M_OP       = 4'd7;
    localparam logic [3:0] M_COMMENT  = 4'd8;
    localparam logic [3:0] M_DONE     = 4'd9;

    localparam int OW = OFFSET_BITS + 24;
    localparam int CW = COUNT_BITS + 16;

    logic [3:0]             r_mode, n_mode;
    logic [OFFSET_BITS-1:0] r_off, n_off, r_soff, n_soff;
    logic [COUNT_BITS-1:0]  r_line, n_line, r_col, n_col;
    logic [COUNT_BITS-1:0]  r_sline, n_sline, r_scol, n_scol, r_cnt, n_cnt;
    logic [47:0]            r_kw, n_kw;
    logic [7:0]             r_op, n_op;
    logic                   r_dot, n_dot, r_esc, n_esc;

    stt_pkg::t_token rec [2];
    logic [1:0]      e;
    logic            fin, again;
    logic [2:0]      kw_len;
    logic [5:0]      pk;

    function automatic logic [COUNT_BITS-1:0] cinc(input logic [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [15:0] c16(input logic [COUNT_BITS-1:0] v);
        logic [CW-1:0] t;
        t = CW'(v);
        return t[15:0];
    endfunction

    // Record built from the token start as it stands at the moment of the emit.
    function automatic stt_pkg::t_token mk(input logic [5:0] kind,
                                           input logic [COUNT_BITS-1:0] len,
                                           input logic [OFFSET_BITS-1:0] off,
                                           input logic [COUNT_BITS-1:0] ln,
                                           input logic [COUNT_BITS-1:0] col);
        stt_pkg::t_token t;
        logic [OW-1:0] o;
        o = OW'(off);
        t.kind   = kind;
        t.offset = o[23:0];
        t.length = c16(len);
        t.line   = c16(ln);
        t.column = c16(col);
        t.last   = 1'b0;
        return t;
    endfunction

    assign kw_len = (r_cnt < COUNT_BITS'(7)) ? r_cnt[2:0] : 3'd7;
    assign pk     = stt_pkg::pair_kind(r_op, i_byte);

    always_comb begin
        n_mode = r_mode; n_off = r_off; n_soff = r_soff; n_line = r_line;
        n_col = r_col; n_sline = r_sline; n_scol = r_scol; n_cnt = r_cnt;
        n_kw = r_kw; n_op = r_op; n_dot = r_dot; n_esc = r_esc;
        rec[0] = '0;
        rec[1] = '0;
        e = 2'd0;
        again = 1'b0;
        fin = i_eot || i_byte == 8'd0;
        if (r_mode == M_DONE) begin
            rec[0] = mk(stt_pkg::K_END, '0, r_soff, r_sline, r_scol);
            e = 2'd1;
        end else begin
            if (!i_eot) begin
                if (i_byte == 8'h0A) begin
                    n_line = cinc(r_line);
                    n_col  = '0;
                end else begin
                    n_col = cinc(r_col);
                end
                n_off = (r_off == '1) ? r_off : r_off + 1'b1;
            end
            if (fin) begin
                // Flush whatever token is open, then the end token.
                unique case (r_mode)
                    M_IDENT: begin
                        rec[0] = mk(stt_pkg::word_kind(r_kw, kw_len), r_cnt,
                                    r_soff, r_sline, r_scol);
                        e = 2'd1;
                    end
                    M_NUM: begin
                        rec[0] = mk(r_dot ? stt_pkg::K_FLOAT : stt_pkg::K_INT, r_cnt,
                                    r_soff, r_sline, r_scol);
                        e = 2'd1;
                    end
                    M_COMMENT: begin
                        rec[0] = mk(stt_pkg::K_COMMENT, r_cnt, r_soff, r_sline, r_scol);
                        e = 2'd1;
                    end
                    M_OP: begin
                        rec[0] = mk(stt_pkg::single_op_kind(r_op), COUNT_BITS'(1),
                                    r_soff, r_sline, r_scol);
                        e = 2'd1;
                    end
                    M_STR: begin
                        rec[0] = mk(stt_pkg::K_ILLEGAL, '0, r_soff, r_sline, r_scol);
                        e = 2'd1;
                    end
                    M_CH_FIRST: begin
                        rec[0] = mk(stt_pkg::K_ILLEGAL, COUNT_BITS'(1),
                                    r_soff, r_sline, r_scol);
                        e = 2'd1;
                    end
                    M_CH_ESC, M_CH_CLOSE: begin
                        rec[0] = mk(stt_pkg::K_ILLEGAL, r_cnt, r_soff, r_sline, r_scol);
                        e = 2'd1;
                    end
                    default: begin
                    end
                endcase
                n_soff  = r_off;
                n_sline = n_line;
                n_scol  = n_col;
                rec[e[0]] = mk(stt_pkg::K_END, '0, r_off, n_line, n_col);
                e = e + 2'd1;
                n_mode = M_DONE;
            end else begin
                unique case (r_mode)
                    M_IDENT: begin
                        if (stt_pkg::is_word(i_byte)) begin
                            n_cnt = cinc(r_cnt);
                            n_kw  = {r_kw[39:0], i_byte};
                        end else begin
                            rec[0] = mk(stt_pkg::word_kind(r_kw, kw_len), r_cnt,
                                        r_soff, r_sline, r_scol);
                            e = 2'd1;
                            again = 1'b1;
                        end
                    end
                    M_NUM: begin
                        if (stt_pkg::is_digit(i_byte) || (!r_dot && i_byte == ".")) begin
                            if (i_byte == ".") n_dot = 1'b1;
                            n_cnt = cinc(r_cnt);
                        end else begin
                            rec[0] = mk(r_dot ? stt_pkg::K_FLOAT : stt_pkg::K_INT, r_cnt,
                                        r_soff, r_sline, r_scol);
                            e = 2'd1;
                            again = 1'b1;
                        end
                    end
                    M_COMMENT: begin
                        if (i_byte != 8'h0A) begin
                            n_cnt = cinc(r_cnt);
                        end else begin
                            rec[0] = mk(stt_pkg::K_COMMENT, r_cnt, r_soff, r_sline, r_scol);
                            e = 2'd1;
                            again = 1'b1;
                        end
                    end
                    M_STR: begin
                        priority if (r_esc) begin
                            n_esc = 1'b0;
                            n_cnt = cinc(r_cnt);
                        end else if (i_byte == "\\") begin
                            n_esc = 1'b1;
                        end else if (i_byte == "\"") begin
                            rec[0] = mk(stt_pkg::K_STRING, r_cnt, r_soff, r_sline, r_scol);
                            e = 2'd1;
                            n_mode = M_IDLE;
                        end else begin
                            n_cnt = cinc(r_cnt);
                        end
                    end
                    M_CH_FIRST: begin
                        n_cnt  = COUNT_BITS'(1);
                        n_mode = (i_byte == "\\") ? M_CH_ESC : M_CH_CLOSE;
                    end
                    M_CH_ESC: begin
                        n_cnt  = COUNT_BITS'(2);
                        n_mode = M_CH_CLOSE;
                    end
                    M_CH_CLOSE: begin
                        if (i_byte == "'") begin
                            rec[0] = mk(stt_pkg::K_CHAR, r_cnt, r_soff, r_sline, r_scol);
                            n_mode = M_IDLE;
                        end else begin
                            rec[0] = mk(stt_pkg::K_ILLEGAL, r_cnt, r_soff, r_sline, r_scol);
                            again = 1'b1;
                        end
                        e = 2'd1;
                    end
                    M_OP: begin
                        if (pk != stt_pkg::K_NONE) begin
                            rec[0] = mk(pk, COUNT_BITS'(2), r_soff, r_sline, r_scol);
                            n_mode = M_IDLE;
                        end else begin
                            rec[0] = mk(stt_pkg::single_op_kind(r_op), COUNT_BITS'(1),
                                        r_soff, r_sline, r_scol);
                            again = 1'b1;
                        end
                        e = 2'd1;
                    end
                    default: again = 1'b1;
                endcase
                // A byte that ends a token or comes while idle opens a new one, unless it is space.
                if (again) begin
                    n_mode = M_IDLE;
                    if (!stt_pkg::is_space(i_byte)) begin
                        n_soff  = r_off;
                        n_sline = n_line;
                        n_scol  = n_col;
                        n_cnt   = COUNT_BITS'(1);
                        priority if (i_byte == "#") begin
                            n_mode = M_COMMENT;
                        end else if (stt_pkg::is_alpha(i_byte)) begin
                            n_kw   = {40'd0, i_byte};
                            n_mode = M_IDENT;
                        end else if (stt_pkg::is_digit(i_byte)) begin
                            n_dot  = 1'b0;
                            n_mode = M_NUM;
                        end else if (i_byte == "\"") begin
                            n_cnt  = '0;
                            n_esc  = 1'b0;
                            n_mode = M_STR;
                        end else if (i_byte == "'") begin
                            n_cnt  = '0;
                            n_mode = M_CH_FIRST;
                        end else if (stt_pkg::is_opchar(i_byte)) begin
                            n_op   = i_byte;
                            n_mode = M_OP;
                        end else begin
                            rec[e[0]] = mk(stt_pkg::punct_kind(i_byte), COUNT_BITS'(1),
                                           r_off, n_line, n_col);
                            e = e + 2'd1;
                        end
                    end
                end
            end
        end
        if (e != 2'd0) rec[e[1]].last = 1'b1;
    end

    assign o_push_n = i_go ? e : 2'd0;
    assign o_tok0   = rec[0];
    assign o_tok1   = rec[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_off   <= '0;
            r_line  <= COUNT_BITS'(1);
            r_col   <= '0;
            r_soff  <= '0;
            r_sline <= COUNT_BITS'(1);
            r_scol  <= '0;
            r_cnt   <= '0;
            r_kw    <= '0;
            r_op    <= '0;
            r_dot   <= 1'b0;
            r_esc   <= 1'b0;
        end else if (i_go) begin
            r_mode  <= n_mode;
            r_off   <= n_off;
            r_line  <= n_line;
            r_col   <= n_col;
            r_soff  <= n_soff;
            r_sline <= n_sline;
            r_scol  <= n_scol;
            r_cnt   <= n_cnt;
            r_kw    <= n_kw;
            r_op    <= n_op;
            r_dot   <= n_dot;
            r_esc   <= n_esc;
        end
    end

    a_done_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == M_DONE |=> r_mode == M_DONE)
        else $error("scanner left the finished state without reset");
    a_done_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && r_mode == M_DONE) |-> o_push_n == 2'd1)
        else $error("finished scanner must give exactly one end token");
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0)
        else $error("line counter reached zero");

endmodule

### rtl/core/stt_queue.sv
`timescale 1ns / 1ps
// Four-entry token queue: takes up to two tokens a cycle, gives one out unless stalled.
// Depends on stt_pkg for the token record type.
module stt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [1:0]      i_push_n,
    input  stt_pkg::t_token i_tok0,
    input  stt_pkg::t_token i_tok1,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_stall,
    output stt_pkg::t_token o_tok
);

    stt_pkg::t_token r_mem [4];
    logic [1:0] r_rd, r_wr;
    logic [2:0] r_cnt, n_cnt;
    logic       pop;

    assign pop     = (r_cnt != 3'd0) && !i_stall;
    assign o_valid = r_cnt != 3'd0;
    assign o_tok   = r_mem[r_rd];
    // Room for two tokens must remain before a new request is taken.
    assign o_full  = r_cnt > 3'd2;
    assign n_cnt   = r_cnt + {1'b0, i_push_n} - {2'b0, pop};

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) r_mem[r_wr] <= i_tok0;
        if (i_push_n == 2'd2) r_mem[r_wr + 2'd1] <= i_tok1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            r_rd  <= r_rd + {1'b0, pop};
            r_wr  <= r_wr + i_push_n;
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("token queue overflow");
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> i_push_n == 2'd0)
        else $error("tokens pushed while queue full");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 3'd4 |-> (r_wr - r_rd) == r_cnt[1:0])
        else $error("queue pointers disagree with fill count");

endmodule

### bench/token_checker.sv
`timescale 1ns / 1ps
// Checker for the source text tokenizer: watches both channels, predicts the tokens.
// Depends on stt_pkg for the token kind codes.
module token_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    input  logic        i_valid_out,
    input  logic        i_stall,
    input  logic [5:0]  i_token_kind,
    input  logic [23:0] i_start_offset,
    input  logic [15:0] i_token_length,
    input  logic [15:0] i_line_number,
    input  logic [15:0] i_column_number,
    input  logic        i_last_of_item,
    output int          o_fail_count,
    output int          o_pending
);

    typedef enum logic [3:0] {
        SCAN_IDLE, SCAN_WORD, SCAN_NUMBER, SCAN_STRING, SCAN_CHAR_OPEN,
        SCAN_CHAR_ESC, SCAN_CHAR_CLOSE, SCAN_OPERATOR, SCAN_COMMENT, SCAN_DONE
    } t_scan;

    typedef struct {
        logic [5:0]  kind;
        logic [23:0] offset;
        logic [15:0] length;
        logic [15:0] line;
        logic [15:0] column;
        logic        last;
    } t_expect;

    localparam logic [47:0] KEYWORDS [13] = '{
        48'("let"), 48'("fn"), 48'("match"), 48'("case"), 48'("return"),
        48'("float"), 48'("int"), 48'("if"), 48'("else"), 48'("for"),
        48'("while"), 48'("true"), 48'("false")};

    t_expect     expected_tokens[$];
    t_expect     step_tokens[$];
    t_scan       scan;
    logic [23:0] cur_offset, tok_offset;
    logic [15:0] cur_line, cur_col, tok_line, tok_col, tok_count;
    logic [47:0] word_bytes;
    logic [7:0]  held_op;
    logic        had_dot, escaping;

    function automatic logic [15:0] bump16(input logic [15:0] v);
        return (v == '1) ? v : v + 16'd1;
    endfunction

    function automatic logic [23:0] bump24(input logic [23:0] v);
        return (v == '1) ? v : v + 24'd1;
    endfunction

    function automatic logic [5:0] classify_word(input logic [47:0] w,
                                                 input logic [15:0] n);
        int width;
        for (int k = 0; k < 13; k++) begin
            width = 0;
            for (int b = 0; b < 6; b++) begin
                if (KEYWORDS[k][8*b +: 8] != 8'd0) width++;
            end
            if (n == 16'(width) && w == KEYWORDS[k]) return 6'(k);
        end
        return stt_pkg::K_IDENT;
    endfunction

    function automatic logic [5:0] lone_op(input logic [7:0] c);
        case (c)
            "+": return stt_pkg::K_PLUS;
            "-": return stt_pkg::K_MINUS;
            "!": return stt_pkg::K_BANG;
            "%": return stt_pkg::K_PERCENT;
            "*": return stt_pkg::K_STAR;
            "/": return stt_pkg::K_SLASH;
            "=": return stt_pkg::K_ASSIGN;
            ">": return stt_pkg::K_GT;
            "<": return stt_pkg::K_LT;
            default: return stt_pkg::K_ILLEGAL;
        endcase
    endfunction

    function automatic logic [5:0] joined_op(input logic [7:0] a, input logic [7:0] b);
        case ({a, b})
            {":", "="}: return stt_pkg::K_COLONEQ;
            {"-", ">"}: return stt_pkg::K_ARROW;
            {"<", "="}: return stt_pkg::K_LE;
            {">", "="}: return stt_pkg::K_GE;
            {"=", "="}: return stt_pkg::K_EQEQ;
            {"!", "="}: return stt_pkg::K_NE;
            {"-", "-"}: return stt_pkg::K_DEC;
            {"+", "+"}: return stt_pkg::K_INC;
            default: return stt_pkg::K_NONE;
        endcase
    endfunction

    function automatic logic [5:0] punct(input logic [7:0] c);
        case (c)
            ",": return stt_pkg::K_COMMA;
            ";": return stt_pkg::K_SEMI;
            "(": return stt_pkg::K_LPAREN;
            ")": return stt_pkg::K_RPAREN;
            "[": return stt_pkg::K_LBRACK;
            "]": return stt_pkg::K_RBRACK;
            "{": return stt_pkg::K_LBRACE;
            "}": return stt_pkg::K_RBRACE;
            default: return stt_pkg::K_ILLEGAL;
        endcase
    endfunction

    function automatic logic letter(input logic [7:0] c);
        return c inside {[8'd65:8'd90], [8'd97:8'd122]};
    endfunction

    function automatic logic digit(input logic [7:0] c);
        return c inside {[8'd48:8'd57]};
    endfunction

    task automatic add_token(input logic [5:0] kind, input logic [15:0] len);
        t_expect e;
        e.kind = kind; e.offset = tok_offset; e.length = len;
        e.line = tok_line; e.column = tok_col; e.last = 1'b0;
        step_tokens.push_back(e);
    endtask

    task automatic begin_token(input logic [7:0] c, input logic [23:0] pos);
        scan = SCAN_IDLE;
        if (c == 8'd32 || c inside {[8'd9:8'd13]}) return;
        tok_offset = pos; tok_line = cur_line; tok_col = cur_col; tok_count = 16'd1;
        if (c == "#") begin
            scan = SCAN_COMMENT;
        end else if (letter(c)) begin
            word_bytes = {40'd0, c};
            scan = SCAN_WORD;
        end else if (digit(c)) begin
            had_dot = 1'b0;
            scan = SCAN_NUMBER;
        end else if (c == "\"") begin
            tok_count = 16'd0;
            escaping = 1'b0;
            scan = SCAN_STRING;
        end else if (c == "'") begin
            tok_count = 16'd0;
            scan = SCAN_CHAR_OPEN;
        end else if (c inside {":", "+", "-", "/", "%", "=", ">", "!", "<", "*"}) begin
            held_op = c;
            scan = SCAN_OPERATOR;
        end else begin
            add_token(punct(c), 16'd1);
        end
    endtask

    // Works out the tokens that one accepted request yields.
    task automatic scan_byte(input logic [7:0] c, input logic eot);
        logic [23:0] pos;
        logic        restart;
        logic [5:0]  pk;
        pos = cur_offset;
        restart = 1'b0;
        step_tokens.delete();
        if (scan == SCAN_DONE) begin
            add_token(stt_pkg::K_END, 16'd0);
        end else begin
            if (!eot) begin
                if (c == 8'd10) begin
                    cur_line = bump16(cur_line);
                    cur_col = 16'd0;
                end else begin
                    cur_col = bump16(cur_col);
                end
                cur_offset = bump24(cur_offset);
            end
            if (eot || c == 8'd0) begin
                // An open token is flushed ahead of the end token.
                case (scan)
                    SCAN_WORD: add_token(classify_word(word_bytes, tok_count), tok_count);
                    SCAN_NUMBER: add_token(had_dot ? stt_pkg::K_FLOAT : stt_pkg::K_INT,
                                           tok_count);
                    SCAN_COMMENT: add_token(stt_pkg::K_COMMENT, tok_count);
                    SCAN_OPERATOR: add_token(lone_op(held_op), 16'd1);
                    SCAN_STRING: add_token(stt_pkg::K_ILLEGAL, 16'd0);
                    SCAN_CHAR_OPEN: add_token(stt_pkg::K_ILLEGAL, 16'd1);
                    SCAN_CHAR_ESC, SCAN_CHAR_CLOSE: add_token(stt_pkg::K_ILLEGAL, tok_count);
                    default: ;
                endcase
                tok_offset = pos; tok_line = cur_line; tok_col = cur_col;
                add_token(stt_pkg::K_END, 16'd0);
                scan = SCAN_DONE;
            end else begin
                case (scan)
                    SCAN_WORD:
                        if (letter(c) || digit(c) || c == "_") begin
                            tok_count = bump16(tok_count);
                            word_bytes = {word_bytes[39:0], c};
                        end else begin
                            add_token(classify_word(word_bytes, tok_count), tok_count);
                            restart = 1'b1;
                        end
                    SCAN_NUMBER:
                        if (digit(c) || (!had_dot && c == ".")) begin
                            if (c == ".") had_dot = 1'b1;
                            tok_count = bump16(tok_count);
                        end else begin
                            add_token(had_dot ? stt_pkg::K_FLOAT : stt_pkg::K_INT,
                                      tok_count);
                            restart = 1'b1;
                        end
                    SCAN_COMMENT:
                        if (c != 8'd10) begin
                            tok_count = bump16(tok_count);
                        end else begin
                            add_token(stt_pkg::K_COMMENT, tok_count);
                            restart = 1'b1;
                        end
                    SCAN_STRING:
                        if (escaping) begin
                            escaping = 1'b0;
                            tok_count = bump16(tok_count);
                        end else if (c == "\\") begin
                            escaping = 1'b1;
                        end else if (c == "\"") begin
                            add_token(stt_pkg::K_STRING, tok_count);
                            scan = SCAN_IDLE;
                        end else begin
                            tok_count = bump16(tok_count);
                        end
                    SCAN_CHAR_OPEN: begin
                        tok_count = 16'd1;
                        scan = (c == "\\") ? SCAN_CHAR_ESC : SCAN_CHAR_CLOSE;
                    end
                    SCAN_CHAR_ESC: begin
                        tok_count = 16'd2;
                        scan = SCAN_CHAR_CLOSE;
                    end
                    SCAN_CHAR_CLOSE:
                        if (c == "'") begin
                            add_token(stt_pkg::K_CHAR, tok_count);
                            scan = SCAN_IDLE;
                        end else begin
                            add_token(stt_pkg::K_ILLEGAL, tok_count);
                            restart = 1'b1;
                        end
                    SCAN_OPERATOR: begin
                        pk = joined_op(held_op, c);
                        if (pk != stt_pkg::K_NONE) begin
                            add_token(pk, 16'd2);
                            scan = SCAN_IDLE;
                        end else begin
                            add_token(lone_op(held_op), 16'd1);
                            restart = 1'b1;
                        end
                    end
                    default: restart = 1'b1;
                endcase
                if (restart) begin_token(c, pos);
            end
        end
        if (step_tokens.size() > 0) step_tokens[$].last = 1'b1;
        foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    endtask

    task automatic check_token();
        t_expect e;
        if (expected_tokens.size() == 0) begin
            $error("token kind %0d arrived with no token expected", i_token_kind);
            o_fail_count++;
            return;
        end
        e = expected_tokens.pop_front();
        if (i_token_kind !== e.kind) begin
            $error("token_kind: expected %0d, got %0d", e.kind, i_token_kind);
            o_fail_count++;
        end
        if (i_start_offset !== e.offset) begin
            $error("start_offset: expected %0d, got %0d", e.offset, i_start_offset);
            o_fail_count++;
        end
        if (i_token_length !== e.length) begin
            $error("token_length: expected %0d, got %0d", e.length, i_token_length);
            o_fail_count++;
        end
        if (i_line_number !== e.line) begin
            $error("line_number: expected %0d, got %0d", e.line, i_line_number);
            o_fail_count++;
        end
        if (i_column_number !== e.column) begin
            $error("column_number: expected %0d, got %0d", e.column, i_column_number);
            o_fail_count++;
        end
        if (i_last_of_item !== e.last) begin
            $error("last_of_item: expected %0d, got %0d", e.last, i_last_of_item);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        scan = SCAN_IDLE;
        cur_offset = '0; tok_offset = '0;
        cur_line = 16'd1; tok_line = 16'd1;
        cur_col = '0; tok_col = '0; tok_count = '0;
        word_bytes = '0; held_op = '0; had_dot = 1'b0; escaping = 1'b0;
    end

    // Outputs are compared before the same edge's request is predicted, since
    // a token never appears in the cycle its request is taken.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid_out && !i_stall) check_token();
            if (i_valid && !i_stall_in) scan_byte(i_text_byte, i_end_of_text);
            o_pending = expected_tokens.size();
        end
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// Top of the tokenizer bench: clock, reset, source text requests and receiver stalls.
// Depends on source_text_tokenizer and token_checker.
module testbench;

    typedef struct {
        logic [7:0] ch;
        logic       eot;
    } t_request;

    logic        i_clk, i_rst_n, i_valid, i_end_of_text, i_stall;
    logic [7:0]  i_text_byte;
    logic        o_stall, o_valid, o_last_of_item;
    logic [5:0]  o_token_kind;
    logic [23:0] o_start_offset;
    logic [15:0] o_token_length, o_line_number, o_column_number;
    int          fail_count, pending;
    bit          sending_done;
    t_request    text_stream[$];

    string keywords [13] = '{"let", "fn", "match", "case", "return", "float", "int",
                             "if", "else", "for", "while", "true", "false"};
    string pairs [8] = '{":=", "->", "<=", ">=", "==", "!=", "--", "++"};
    string singles = "+-!%*/=><:";
    string puncts = ",;()[]{}";
    string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";

    source_text_tokenizer u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_text_byte(i_text_byte), .i_end_of_text(i_end_of_text),
        .o_valid(o_valid), .i_stall(i_stall), .o_token_kind(o_token_kind),
        .o_start_offset(o_start_offset), .o_token_length(o_token_length),
        .o_line_number(o_line_number), .o_column_number(o_column_number),
        .o_last_of_item(o_last_of_item)
    );

    token_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_text_byte(i_text_byte), .i_end_of_text(i_end_of_text),
        .i_valid_out(o_valid), .i_stall(i_stall), .i_token_kind(o_token_kind),
        .i_start_offset(o_start_offset), .i_token_length(o_token_length),
        .i_line_number(o_line_number), .i_column_number(o_column_number),
        .i_last_of_item(o_last_of_item), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("testbench failed");
        $finish;
    end

    // Mostly no gap, some short ones and the odd long one.
    function automatic int idle_cycles(input bit busy_phase);
        int r;
        if (busy_phase) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic push_text(input string s);
        t_request r;
        for (int i = 0; i < s.len(); i++) begin
            r.ch = s[i];
            r.eot = 1'b0;
            text_stream.push_back(r);
        end
    endtask

    task automatic push_char(input logic [7:0] c);
        t_request r;
        r.ch = c;
        r.eot = 1'b0;
        text_stream.push_back(r);
    endtask

    function automatic string random_word(input int n, input bit lead_letter);
        string s;
        s = "";
        for (int i = 0; i < n; i++) begin
            s = {s, string'(word_chars[lead_letter && i == 0 ?
                 $urandom_range(51) : $urandom_range(62)])};
        end
        return s;
    endfunction

    task automatic push_fragment();
        int sel;
        sel = $urandom_range(13);
        case (sel)
            0: push_text(keywords[$urandom_range(12)]);
            1: push_text(random_word($urandom_range(9, 1), 1'b1));
            2: push_text($sformatf("%0d", $urandom_range(99999)));
            3: push_text($urandom_range(3) == 0 ? "1.2.3" :
                         $sformatf("%0d.%0d", $urandom_range(999), $urandom_range(99)));
            4: begin
                push_char("\"");
                repeat ($urandom_range(6)) begin
                    if ($urandom_range(3) == 0) push_char("\\");
                    push_char(8'($urandom_range(255, 1)));
                end
                push_char("\"");
            end
            5: push_text({"'", random_word(1, 1'b0), "'"});
            6: push_text({"'\\", random_word(1, 1'b0), "'"});
            // A character literal that fails to close.
            7: push_text($urandom_range(1) ? {"'", random_word(2, 1'b1)} : "'\\nq");
            8: push_text(pairs[$urandom_range(7)]);
            9: push_char(singles[$urandom_range(9)]);
            10: push_char(puncts[$urandom_range(7)]);
            11: begin
                push_text({"#", random_word($urandom_range(12), 1'b0)});
                push_char(8'd10);
            end
            12: push_char($urandom_range(1) ? 8'd32 : 8'($urandom_range(13, 9)));
            default: push_char(8'($urandom_range(255, 1)));
        endcase
        if ($urandom_range(9) < 6) push_char($urandom_range(4) == 0 ? 8'd10 : 8'd32);
    endtask

    task automatic build_stimulus();
        t_request r;
        push_text("let x:=1.5;'\\n''ab#c");
        push_char(8'd10);
        push_text("$ y->9 @");
        while (text_stream.size() < 650) push_fragment();
        // Sometimes the text ends inside an open string.
        if ($urandom_range(3) == 0) push_char("\"");
        r.ch = 8'($urandom_range(255));
        r.eot = 1'b1;
        if ($urandom_range(1)) begin
            r.ch = 8'd0;
            r.eot = 1'b0;
        end
        text_stream.push_back(r);
        repeat (6) begin
            r.ch = 8'($urandom_range(255));
            r.eot = 1'($urandom_range(1));
            text_stream.push_back(r);
        end
    endtask

    initial begin
        int gap;
        bit busy;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_text_byte = 8'd0;
        i_end_of_text = 1'b0;
        sending_done = 0;
        build_stimulus();
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        busy = 0;
        foreach (text_stream[i]) begin
            if ($urandom_range(49) == 0) busy = ~busy;
            gap = idle_cycles(busy);
            if (gap > 0) begin
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_valid = 1'b1;
            i_text_byte = text_stream[i].ch;
            i_end_of_text = text_stream[i].eot;
            forever begin
                @(posedge i_clk);
                if (!o_stall) break;
            end
            @(negedge i_clk);
        end
        i_valid = 1'b0;
        sending_done = 1;
    end

    initial begin
        bit busy;
        int gap;
        i_stall = 1'b0;
        busy = 0;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(29) == 0) busy = ~busy;
            gap = idle_cycles(busy);
            @(negedge i_clk);
            if (gap > 0) begin
                i_stall = 1'b1;
                repeat (gap - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            i_stall = 1'b0;
        end
    end

    initial begin
        wait (sending_done);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
